// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/cpt_pkg.sv -----
// Package with the opcodes, control word fields and prescaler helpers of the timer bank.
package cpt_pkg;

	// Fixed field widths.
	localparam int CNT_W = 16;
	localparam int RES_W = 10;
	localparam int CYC_W = 12;
	localparam int SUM_W = 13;
	localparam int MAX_TIMERS = 8;

	// Operation codes.
	localparam logic [1:0] OP_RELOAD  = 2'd0;
	localparam logic [1:0] OP_CONTROL = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_STEP    = 2'd3;

	// Control word bit positions.
	localparam int CTL_CASCADE = 2;
	localparam int CTL_IRQ     = 6;
	localparam int CTL_ENABLE  = 7;

	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	// Ticks produced by a residue-plus-cycles sum for a prescaler code.
	function automatic logic [SUM_W-1:0] pre_ticks(input logic [1:0] code,
			input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] t;
		case (code)
			2'd0: t = sum;
			2'd1: t = sum >> 6;
			2'd2: t = sum >> 8;
			default: t = sum >> 10;
		endcase
		return t;
	endfunction

	// Cycles left over after the ticks are taken out.
	function automatic logic [RES_W-1:0] pre_residue(input logic [1:0] code,
			input logic [SUM_W-1:0] sum);
		logic [RES_W-1:0] r;
		case (code)
			2'd0: r = '0;
			2'd1: r = sum[RES_W-1:0] & 10'h03F;
			2'd2: r = sum[RES_W-1:0] & 10'h0FF;
			default: r = sum[RES_W-1:0] & 10'h3FF;
		endcase
		return r;
	endfunction

endpackage

// ----- src/cascaded_prescaled_timer_bank.sv -----
// Top level of the cascaded prescaled timer bank: state, step logic and output buffer.
// Throughput: one beat per cycle while the skid entry is empty; the whole step, including
// the cascade ripple through all timers, is evaluated in one pass between the input and
// the result register (the output register, or the skid entry while the output stalls).
// A two-entry output buffer keeps taking input beats while one result is stalled.
// Reset (arst_n low, asynchronous) clears all counters, reloads, controls and residues.
module cascaded_prescaled_timer_bank import cpt_pkg::*; #(
	parameter int NUM_TIMERS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [1:0]        timer_index,
	input  logic [CNT_W-1:0]  write_data,
	input  logic [CYC_W-1:0]  elapsed_cycles,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CNT_W-1:0]  read_data,
	output logic [3:0]        irq_bits,
	output logic [1:0]        sound_overflow
);

	logic [CNT_W-1:0] reload_q [NUM_TIMERS];
	logic [CNT_W-1:0] count_q  [NUM_TIMERS];
	logic [CNT_W-1:0] ctl_q    [NUM_TIMERS];
	logic [RES_W-1:0] res_q    [NUM_TIMERS];

	logic [CNT_W-1:0] reload_d [NUM_TIMERS];
	logic [CNT_W-1:0] count_d  [NUM_TIMERS];
	logic [CNT_W-1:0] ctl_d    [NUM_TIMERS];
	logic [RES_W-1:0] res_d    [NUM_TIMERS];

	logic [CNT_W-1:0] rd_d;
	logic [3:0]       irq_d;
	logic [1:0]       snd_d;

	logic             accept;

	// Output register and skid entry.
	logic             out_valid_q, skid_valid_q;
	logic [CNT_W-1:0] out_rd_q, skid_rd_q;
	logic [3:0]       out_irq_q, skid_irq_q;
	logic [1:0]       out_snd_q, skid_snd_q;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;

	// Next state and result of the beat at the input.
	always_comb begin
		logic                 hit, en, casc, carry, ovf;
		logic [SUM_W-1:0]     sum, ticks;
		logic [CNT_W:0]       cplus;
		logic [MAX_TIMERS-1:0] ovf_all, irq_all;
		reload_d = reload_q;
		count_d  = count_q;
		ctl_d    = ctl_q;
		res_d    = res_q;
		rd_d     = '0;
		ovf_all  = '0;
		irq_all  = '0;
		carry    = 1'b0;
		for (int k = 0; k < NUM_TIMERS; k++) begin
			hit   = (int'(timer_index) == k);
			en    = ctl_q[k][CTL_ENABLE];
			casc  = (k > 0) && ctl_q[k][CTL_CASCADE];
			sum   = SUM_W'(res_q[k]) + SUM_W'(elapsed_cycles);
			ticks = pre_ticks(ctl_q[k][1:0], sum);
			cplus = {1'b0, count_q[k]} + (CNT_W+1)'(ticks);
			ovf   = 1'b0;
			case (op)
				OP_RELOAD: begin
					if (hit) reload_d[k] = write_data;
				end
				OP_CONTROL: begin
					if (hit) begin
						ctl_d[k] = write_data;
						if (!en && write_data[CTL_ENABLE]) begin
							count_d[k] = reload_q[k];
							res_d[k]   = '0;
						end
					end
				end
				OP_READ: begin
					if (hit) rd_d = rd_d | count_q[k];
				end
				OP_STEP: begin
					if (en && !casc) begin
						// Prescaled timer: add its ticks, reload once on overflow.
						res_d[k] = pre_residue(ctl_q[k][1:0], sum);
						if (ticks != '0) begin
							if (cplus[CNT_W]) begin
								ovf        = 1'b1;
								count_d[k] = reload_q[k];
							end else begin
								count_d[k] = cplus[CNT_W-1:0];
							end
						end
					end else if (en && casc && carry) begin
						// Cascaded timer: count one overflow of its predecessor.
						if (count_q[k] == CNT_MAX) begin
							ovf        = 1'b1;
							count_d[k] = reload_q[k];
						end else begin
							count_d[k] = count_q[k] + 1'b1;
						end
					end
				end
				default: ;
			endcase
			carry      = ovf;
			ovf_all[k] = ovf;
			irq_all[k] = ovf && ctl_q[k][CTL_IRQ];
		end
		irq_d = irq_all[3:0];
		snd_d = ovf_all[1:0];
	end

	// Timer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TIMERS; k++) begin
				reload_q[k] <= '0;
				count_q[k]  <= '0;
				ctl_q[k]    <= '0;
				res_q[k]    <= '0;
			end
		end else if (accept) begin
			reload_q <= reload_d;
			count_q  <= count_d;
			ctl_q    <= ctl_d;
			res_q    <= res_d;
		end
	end

	// Output valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output payload: the skid entry moves up first, else the new result.
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_rd_q  <= skid_rd_q;
				out_irq_q <= skid_irq_q;
				out_snd_q <= skid_snd_q;
			end else if (accept) begin
				out_rd_q  <= rd_d;
				out_irq_q <= irq_d;
				out_snd_q <= snd_d;
			end
		end else if (accept) begin
			skid_rd_q  <= rd_d;
			skid_irq_q <= irq_d;
			skid_snd_q <= snd_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = out_rd_q;
	assign irq_bits       = out_irq_q;
	assign sound_overflow = out_snd_q;

endmodule

// ----- src/cpt_checker.sv -----
// Port-level checker for the timer bank and its bind to the top level.
`include "assert_macros.svh"

module cpt_checker import cpt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        op,
	input logic [1:0]        timer_index,
	input logic [CNT_W-1:0]  write_data,
	input logic [CYC_W-1:0]  elapsed_cycles,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CNT_W-1:0]  read_data,
	input logic [3:0]        irq_bits,
	input logic [1:0]        sound_overflow
);

	// A stalled result beat keeps its payload.
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(irq_bits) && $stable(sound_overflow), "stalled result changed")

	// The input side only stalls while a result is pending.
	`ASSERT_ALWAYS(a_stall_has_result, in_ready || out_valid, "input stalled with no result pending")

	// A full buffer stays full while the output is stalled.
	`ASSERT_NEXT(a_full_holds, !in_ready && !out_ready, !in_ready, "buffer drained without an output beat")

	// A read result carries no step flags.
	`ASSERT_ALWAYS(a_read_no_flags, !(out_valid && read_data != '0) || (irq_bits == '0 && sound_overflow == '0), "read result with overflow flags")

endmodule

bind cascaded_prescaled_timer_bank cpt_checker u_cpt_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the cascaded prescaled timer bank.
module testbench;
	import cpt_pkg::*;

	localparam int TIMERS = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	// Control word fields built from the package bit positions.
	localparam logic [CNT_W-1:0] CW_CASCADE = 16'd1 << CTL_CASCADE;
	localparam logic [CNT_W-1:0] CW_IRQ = 16'd1 << CTL_IRQ;
	localparam logic [CNT_W-1:0] CW_ENABLE = 16'd1 << CTL_ENABLE;
	localparam logic [CNT_W-1:0] CW_DIV1024 = 16'd3;
	localparam logic [CNT_W-1:0] CW_DIV64 = 16'd1;

	typedef struct packed {
		logic [CNT_W-1:0] rd;
		logic [3:0] irq;
		logic [1:0] snd;
	} timer_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] op;
	logic [1:0] timer_index;
	logic [CNT_W-1:0] write_data;
	logic [CYC_W-1:0] elapsed_cycles;
	logic out_valid;
	logic out_ready;
	logic [CNT_W-1:0] read_data;
	logic [3:0] irq_bits;
	logic [1:0] sound_overflow;

	// Shadow copy of the timer state that the expected results are computed from.
	logic [CNT_W-1:0] shadow_reload [TIMERS];
	logic [CNT_W-1:0] shadow_count [TIMERS];
	logic [CNT_W-1:0] shadow_ctrl [TIMERS];
	logic [RES_W-1:0] shadow_residue [TIMERS];

	timer_result_t expected_results [$];
	timer_result_t oldest;
	int send_idle;
	int recv_idle;
	int beats_sent;
	int beats_checked;
	int overflow_beats;
	int directed_beats;
	int errors;
	int cycle_count;

	// Free-running clock with a period of 12.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	cascaded_prescaled_timer_bank #(.NUM_TIMERS(TIMERS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.timer_index(timer_index),
		.write_data(write_data),
		.elapsed_cycles(elapsed_cycles),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.irq_bits(irq_bits),
		.sound_overflow(sound_overflow)
	);

	// Reload an overflowing timer and carry the overflow into cascaded successors.
	function automatic void overflow_ripple(input int first, inout logic [3:0] irq,
			inout logic [1:0] snd);
		int k;
		bit more;
		k = first;
		more = 1'b1;
		while (more) begin
			shadow_count[k] = shadow_reload[k];
			if (shadow_ctrl[k][CTL_IRQ] && k < 4)
				irq[k] = 1'b1;
			if (k < 2)
				snd[k] = 1'b1;
			if (k + 1 >= TIMERS) begin
				more = 1'b0;
			end else begin
				k++;
				if (!shadow_ctrl[k][CTL_ENABLE] || !shadow_ctrl[k][CTL_CASCADE]) begin
					more = 1'b0;
				end else if (shadow_count[k] != CNT_MAX) begin
					shadow_count[k] = shadow_count[k] + 16'd1;
					more = 1'b0;
				end
			end
		end
	endfunction

	// Apply one beat to the shadow state and return the result it should produce.
	function automatic timer_result_t timer_bank_result(input logic [1:0] o,
			input logic [1:0] ix, input logic [CNT_W-1:0] d, input logic [CYC_W-1:0] c);
		timer_result_t r;
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] ticks;
		logic [SUM_W-1:0] mask;
		logic [CNT_W:0] total;
		int shift;
		int k;
		r = '0;
		case (o)
			OP_RELOAD: begin
				shadow_reload[ix] = d;
			end
			OP_CONTROL: begin
				// Only a disabled-to-enabled transition restarts the counter.
				if (!shadow_ctrl[ix][CTL_ENABLE] && d[CTL_ENABLE]) begin
					shadow_count[ix] = shadow_reload[ix];
					shadow_residue[ix] = '0;
				end
				shadow_ctrl[ix] = d;
			end
			OP_READ: begin
				r.rd = shadow_count[ix];
			end
			default: begin
				for (k = 0; k < TIMERS; k++) begin
					if (!shadow_ctrl[k][CTL_ENABLE] || (k > 0 && shadow_ctrl[k][CTL_CASCADE]))
						continue;
					case (shadow_ctrl[k][1:0])
						2'd0: shift = 0;
						2'd1: shift = 6;
						2'd2: shift = 8;
						default: shift = 10;
					endcase
					mask = (13'd1 << shift) - 13'd1;
					sum = SUM_W'(shadow_residue[k]) + SUM_W'(c);
					ticks = sum >> shift;
					shadow_residue[k] = RES_W'(sum & mask);
					if (ticks == '0)
						continue;
					total = (CNT_W+1)'(shadow_count[k]) + (CNT_W+1)'(ticks);
					if (total > (CNT_W+1)'(CNT_MAX))
						overflow_ripple(k, r.irq, r.snd);
					else
						shadow_count[k] = total[CNT_W-1:0];
				end
			end
		endcase
		return r;
	endfunction

	// Drive one input beat, wait for its handshake and record its expected result.
	task automatic send_beat(input logic [1:0] o, input logic [1:0] ix,
			input logic [CNT_W-1:0] d, input logic [CYC_W-1:0] c);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		op = o;
		timer_index = ix;
		write_data = d;
		elapsed_cycles = c;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(timer_bank_result(o, ix, d, c));
		beats_sent++;
		@(negedge clk);
	endtask

	// Reload values lean toward the top so overflows happen often.
	function automatic logic [CNT_W-1:0] random_reload();
		if ($urandom_range(99) < 50)
			return CNT_MAX - CNT_W'($urandom_range(300));
		return CNT_W'($urandom);
	endfunction

	// Control words with random fields, enabled most of the time.
	function automatic logic [CNT_W-1:0] random_control();
		logic [CNT_W-1:0] w;
		w = CNT_W'($urandom);
		w[CTL_ENABLE] = ($urandom_range(99) < 80);
		return w;
	endfunction

	// Step lengths mixing tiny, mid-sized, full-range and maximum values.
	function automatic logic [CYC_W-1:0] random_cycles();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return CYC_W'($urandom_range(3));
		if (pick < 40)
			return CYC_W'($urandom_range(70));
		if (pick < 50)
			return {CYC_W{1'b1}};
		if (pick < 60)
			return CYC_W'($urandom_range(1100));
		return CYC_W'($urandom);
	endfunction

	// Counters read zero and a step does nothing while all timers are disabled.
	task automatic test_after_reset();
		send_beat(OP_READ, 2'd0, 16'h0000, 12'h000);
		send_beat(OP_READ, 2'd3, 16'hFFFF, 12'hFFF);
		send_beat(OP_STEP, 2'd3, 16'hFFFF, 12'hFFF);
	endtask

	// An overflow of timer 0 ripples through a saturated cascaded timer 1 into timer 2.
	// Timer 0 also carries the cascade bit, which it must ignore.
	task automatic test_cascade_ripple();
		send_beat(OP_RELOAD, 2'd0, 16'hFFF0, 12'h000);
		send_beat(OP_CONTROL, 2'd0, CW_ENABLE | CW_IRQ | CW_CASCADE, 12'h000);
		send_beat(OP_RELOAD, 2'd1, 16'hFFFF, 12'h000);
		send_beat(OP_CONTROL, 2'd1, CW_ENABLE | CW_IRQ | CW_CASCADE, 12'h000);
		send_beat(OP_RELOAD, 2'd2, 16'h0000, 12'h000);
		send_beat(OP_CONTROL, 2'd2, CW_ENABLE | CW_CASCADE, 12'h000);
		send_beat(OP_STEP, 2'd0, 16'h0000, 12'd0);
		send_beat(OP_STEP, 2'd0, 16'h0000, 12'd15);
		send_beat(OP_STEP, 2'd0, 16'h0000, 12'd1);
		send_beat(OP_READ, 2'd0, 16'h0000, 12'h000);
		send_beat(OP_READ, 2'd1, 16'h0000, 12'h000);
		send_beat(OP_READ, 2'd2, 16'h0000, 12'h000);
	endtask

	// Reload and control rewrites on a running timer, then the coarse prescalers.
	task automatic test_prescaler_and_rewrite();
		send_beat(OP_RELOAD, 2'd0, 16'h0000, 12'h000);
		send_beat(OP_CONTROL, 2'd0, 16'hFF00 | CW_ENABLE | CW_IRQ | CW_DIV1024, 12'h000);
		send_beat(OP_STEP, 2'd1, 16'h1234, 12'hFFF);
		send_beat(OP_STEP, 2'd2, 16'h0000, 12'd1);
		send_beat(OP_RELOAD, 2'd3, 16'hFFFF, 12'h000);
		send_beat(OP_CONTROL, 2'd3, CW_ENABLE | CW_IRQ | CW_DIV64, 12'h000);
		send_beat(OP_STEP, 2'd0, 16'h0000, 12'd64);
		send_beat(OP_CONTROL, 2'd1, 16'h0000, 12'h000);
		send_beat(OP_READ, 2'd0, 16'h0000, 12'h000);
	endtask

	// Mostly configure-then-run sequences with random content, plus raw noise beats.
	task automatic test_random_traffic(input int count);
		int stop_at;
		int n;
		int t;
		stop_at = beats_sent + count;
		while (beats_sent < stop_at) begin
			if ($urandom_range(99) < 85) begin
				for (t = 0; t < TIMERS; t++) begin
					if ($urandom_range(99) < 50) begin
						if ($urandom_range(1))
							send_beat(OP_RELOAD, 2'(t), random_reload(), CYC_W'($urandom));
						send_beat(OP_CONTROL, 2'(t), random_control(), CYC_W'($urandom));
					end
				end
				n = $urandom_range(20, 6);
				repeat (n) begin
					if ($urandom_range(99) < 70)
						send_beat(OP_STEP, 2'($urandom), CNT_W'($urandom), random_cycles());
					else
						send_beat(OP_READ, 2'($urandom), CNT_W'($urandom), CYC_W'($urandom));
				end
			end else begin
				send_beat(2'($urandom), 2'($urandom), CNT_W'($urandom), CYC_W'($urandom));
			end
		end
	endtask

	// Receiver readiness is redrawn every cycle.
	always @(negedge clk)
		out_ready = ($urandom_range(99) >= recv_idle);

	// Compare each result beat with the oldest expected result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, actual %h/%h/%h",
					$time, read_data, irq_bits, sound_overflow);
			end else begin
				oldest = expected_results.pop_front();
				beats_checked++;
				if (oldest.irq != '0 || oldest.snd != '0)
					overflow_beats++;
				if (read_data !== oldest.rd) begin
					errors++;
					$display("%0t: read_data expected %h actual %h", $time, oldest.rd, read_data);
				end
				if (irq_bits !== oldest.irq) begin
					errors++;
					$display("%0t: irq_bits expected %h actual %h", $time, oldest.irq, irq_bits);
				end
				if (sound_overflow !== oldest.snd) begin
					errors++;
					$display("%0t: sound_overflow expected %h actual %h",
						$time, oldest.snd, sound_overflow);
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles with %0d results outstanding",
				$time, CYCLE_LIMIT, expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Reset, directed tests, random traffic in three phases with different idling, then drain.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_RELOAD;
		timer_index = 2'd0;
		write_data = '0;
		elapsed_cycles = '0;
		out_ready = 1'b0;
		send_idle = 22;
		recv_idle = 49;
		beats_sent = 0;
		beats_checked = 0;
		overflow_beats = 0;
		errors = 0;
		cycle_count = 0;
		for (int k = 0; k < TIMERS; k++) begin
			shadow_reload[k] = '0;
			shadow_count[k] = '0;
			shadow_ctrl[k] = '0;
			shadow_residue[k] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_after_reset();
		test_cascade_ripple();
		test_prescaler_and_rewrite();
		directed_beats = beats_sent;

		test_random_traffic(610);
		send_idle = 49;
		recv_idle = 22;
		test_random_traffic(610);
		send_idle = 0;
		recv_idle = 0;
		test_random_traffic(600);
		in_valid = 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d beats (%0d directed) and checked %0d results, %0d with overflows.",
			beats_sent, directed_beats, beats_checked, overflow_beats);
		$display("Traffic ran with sender-heavy, receiver-heavy and no idling.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
